>>> src/stt_pkg.sv
package stt_pkg;

  localparam int unsigned LINE_W = 20;
  localparam int unsigned COL_W  = 16;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned SUM_W  = ((COL_W > LEN_W) ? COL_W : LEN_W) + 1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [3:0]        token_kind;
    logic [LINE_W-1:0] start_line;
    logic [COL_W-1:0]  start_column;
    logic [LEN_W-1:0]  token_length;
    logic [2:0]        error_code;
    logic              end_of_run;
  } out_t;

  typedef enum logic [4:0] {
    MODE_IDLE, MODE_IDENT, MODE_MINUS, MODE_ZERO, MODE_HEX0, MODE_HEX, MODE_DEC,
    MODE_DECDOT, MODE_FRAC, MODE_STR, MODE_PCT0, MODE_PNAME, MODE_HASH0,
    MODE_HNAME, MODE_HASHDOT, MODE_SLASH, MODE_LINE, MODE_BLOCK, MODE_BLOCKSTAR,
    MODE_SYM, MODE_BAD, MODE_HALT
  } mode_e;

  // token kinds
  localparam logic [3:0] KIND_IDENT  = 4'd0;
  localparam logic [3:0] KIND_NUMBER = 4'd1;
  localparam logic [3:0] KIND_STRING = 4'd2;
  localparam logic [3:0] KIND_PCT    = 4'd3;
  localparam logic [3:0] KIND_HASH   = 4'd4;
  localparam logic [3:0] KIND_LBRACE = 4'd5;
  localparam logic [3:0] KIND_RBRACE = 4'd6;
  localparam logic [3:0] KIND_LBRACK = 4'd7;
  localparam logic [3:0] KIND_RBRACK = 4'd8;
  localparam logic [3:0] KIND_STAR   = 4'd9;
  localparam logic [3:0] KIND_DOT    = 4'd10;
  localparam logic [3:0] KIND_COLON  = 4'd11;
  localparam logic [3:0] KIND_EQUALS = 4'd12;
  localparam logic [3:0] KIND_SEMI   = 4'd13;
  localparam logic [3:0] KIND_END    = 4'd14;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_COMMENT = 3'd1;
  localparam logic [2:0] ERR_NOHEX   = 3'd2;
  localparam logic [2:0] ERR_STRING  = 3'd3;
  localparam logic [2:0] ERR_NAME    = 3'd4;
  localparam logic [2:0] ERR_BADCHAR = 3'd5;

  // characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDER);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_letter(c) || is_digit(c);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
           (c == CH_FF);
  endfunction

  // zero for a byte that is no symbol
  function automatic logic [3:0] sym_kind(logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_STAR:   k = KIND_STAR;
      CH_DOT:    k = KIND_DOT;
      CH_COLON:  k = KIND_COLON;
      CH_EQUALS: k = KIND_EQUALS;
      CH_SEMI:   k = KIND_SEMI;
      default:   k = KIND_IDENT;
    endcase
    return k;
  endfunction

  // mode entered by the first byte of a token
  function automatic mode_e start_mode(logic [7:0] c);
    mode_e m;
    if (is_space(c))                m = MODE_IDLE;
    else if (is_letter(c))          m = MODE_IDENT;
    else if (c == CH_ZERO)          m = MODE_ZERO;
    else if (is_digit(c))           m = MODE_DEC;
    else if (c == CH_MINUS)         m = MODE_MINUS;
    else if (c == CH_QUOTE)         m = MODE_STR;
    else if (c == CH_PCT)           m = MODE_PCT0;
    else if (c == CH_HASH)          m = MODE_HASH0;
    else if (c == CH_SLASH)         m = MODE_SLASH;
    else if (sym_kind(c) != KIND_IDENT) m = MODE_SYM;
    else                            m = MODE_BAD;
    return m;
  endfunction

endpackage

>>> src/source_text_tokenizer_core.sv
// Streaming source tokenizer. One byte (or the end-of-source word) is taken
// per cycle while in_ready_o is high; each word yields zero, one or two token
// records, which wait in a four-entry result queue drained one record per
// cycle while out_ready_i is high. in_ready_o falls only while the queue has
// fewer than two free entries, so bytes are taken while older records wait,
// but two-record words in a row can stall input even with the output ready.
// No start-up clearing pass: the block is ready straight after reset.
module source_text_tokenizer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  stt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output stt_pkg::out_t out_data_o
);
  import stt_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  mode_e             mode_q, mode_d;
  logic [7:0]        pend_q, pend_d;
  logic [LINE_W-1:0] cur_line_q, cur_line_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [LINE_W-1:0] st_line_q, st_line_d;
  logic [COL_W-1:0]  st_col_q, st_col_d;
  logic [LEN_W-1:0]  count_q, count_d;
  logic              esc_q, esc_d;

  out_t              queue_q [QDEPTH];
  logic [QPTR_W-1:0] head_q, tail_q;
  logic [QPTR_W:0]   fill_q;

  logic              in_fire, out_fire;
  logic [7:0]        ch;
  logic              eos;
  logic [LEN_W-1:0]  count_inc1, count_inc2;
  logic [COL_W-1:0]  dot_col;
  logic [1:0]        n_res;
  out_t              rec0, rec1;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign ch       = in_data_i.char_code;
  assign eos      = in_data_i.end_of_source;

  // saturating length and dot-position sums
  always_comb begin
    logic [LEN_W:0] s1, s2;
    logic [SUM_W-1:0] sd;
    s1 = {1'b0, count_q} + (LEN_W+1)'(1);
    s2 = {1'b0, count_q} + (LEN_W+1)'(2);
    count_inc1 = s1[LEN_W] ? {LEN_W{1'b1}} : s1[LEN_W-1:0];
    count_inc2 = s2[LEN_W] ? {LEN_W{1'b1}} : s2[LEN_W-1:0];
    sd = SUM_W'(st_col_q) + SUM_W'(count_q);
    dot_col = (sd > SUM_W'({COL_W{1'b1}})) ? {COL_W{1'b1}} : sd[COL_W-1:0];
  end

  // next state
  always_comb begin
    logic take_begin;
    take_begin = 1'b0;
    mode_d     = mode_q;
    pend_d     = pend_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    st_line_d  = st_line_q;
    st_col_d   = st_col_q;
    count_d    = count_q;
    esc_d      = esc_q;
    if (eos) begin
      mode_d     = MODE_IDLE;
      pend_d     = '0;
      cur_line_d = LINE_W'(1);
      cur_col_d  = COL_W'(1);
      st_line_d  = LINE_W'(1);
      st_col_d   = COL_W'(1);
      count_d    = '0;
      esc_d      = 1'b0;
    end else begin
      if (ch == CH_LF) begin
        cur_line_d = (&cur_line_q) ? cur_line_q : cur_line_q + LINE_W'(1);
        cur_col_d  = COL_W'(1);
      end else begin
        cur_col_d  = (&cur_col_q) ? cur_col_q : cur_col_q + COL_W'(1);
      end
      unique case (mode_q)
        MODE_IDLE: take_begin = 1'b1;
        MODE_IDENT, MODE_PNAME: begin
          if (is_alnum(ch)) count_d = count_inc1;
          else take_begin = 1'b1;
        end
        MODE_MINUS: begin
          if (is_digit(ch)) begin
            count_d = count_inc1;
            mode_d  = (ch == CH_ZERO) ? MODE_ZERO : MODE_DEC;
          end else begin
            mode_d = MODE_HALT;
          end
        end
        MODE_ZERO: begin
          if (ch == CH_LOWER_X || ch == CH_UPPER_X) begin
            count_d = count_inc1;
            mode_d  = MODE_HEX0;
          end else if (is_digit(ch)) begin
            count_d = count_inc1;
            mode_d  = MODE_DEC;
          end else if (ch == CH_DOT) begin
            mode_d = MODE_DECDOT;
          end else begin
            take_begin = 1'b1;
          end
        end
        MODE_HEX0: begin
          if (is_hex(ch)) begin
            count_d = count_inc1;
            mode_d  = MODE_HEX;
          end else begin
            mode_d = MODE_HALT;
          end
        end
        MODE_HEX: begin
          if (is_hex(ch)) count_d = count_inc1;
          else take_begin = 1'b1;
        end
        MODE_DEC: begin
          if (is_digit(ch)) count_d = count_inc1;
          else if (ch == CH_DOT) mode_d = MODE_DECDOT;
          else take_begin = 1'b1;
        end
        MODE_DECDOT: begin
          if (is_digit(ch)) begin
            count_d = count_inc2;
            mode_d  = MODE_FRAC;
          end else begin
            take_begin = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit(ch)) count_d = count_inc1;
          else take_begin = 1'b1;
        end
        MODE_STR: begin
          count_d = count_inc1;
          if (ch == CH_QUOTE && !esc_q) mode_d = MODE_IDLE;
          else esc_d = (ch == CH_BSLASH) && !esc_q;
        end
        MODE_PCT0: begin
          if (is_letter(ch)) begin
            count_d = count_inc1;
            mode_d  = MODE_PNAME;
          end else begin
            mode_d = MODE_HALT;
          end
        end
        MODE_HASH0: begin
          if (is_letter(ch)) begin
            count_d = count_inc1;
            mode_d  = MODE_HNAME;
          end else begin
            mode_d = MODE_HALT;
          end
        end
        MODE_HNAME: begin
          if (is_alnum(ch)) count_d = count_inc1;
          else if (ch == CH_DOT) mode_d = MODE_HASHDOT;
          else take_begin = 1'b1;
        end
        MODE_HASHDOT: begin
          if (is_letter(ch)) begin
            count_d = count_inc2;
            mode_d  = MODE_HNAME;
          end else begin
            take_begin = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (ch == CH_SLASH) mode_d = MODE_LINE;
          else if (ch == CH_STAR) mode_d = MODE_BLOCK;
          else mode_d = MODE_HALT;
        end
        MODE_LINE: begin
          if (ch == CH_LF) mode_d = MODE_IDLE;
        end
        MODE_BLOCK: begin
          if (ch == CH_STAR) mode_d = MODE_BLOCKSTAR;
        end
        MODE_BLOCKSTAR: begin
          if (ch == CH_SLASH) mode_d = MODE_IDLE;
          else if (ch != CH_STAR) mode_d = MODE_BLOCK;
        end
        MODE_SYM: take_begin = 1'b1;
        default: mode_d = MODE_HALT;
      endcase
      if (take_begin) begin
        st_line_d = cur_line_q;
        st_col_d  = cur_col_q;
        count_d   = LEN_W'(1);
        esc_d     = 1'b0;
        mode_d    = start_mode(ch);
        if (start_mode(ch) == MODE_SYM) pend_d = ch;
      end
    end
  end

  // result records
  always_comb begin
    out_t tok_r, dot_r, sym_r, end_r;
    tok_r = '{token_kind: KIND_IDENT, start_line: st_line_q, start_column: st_col_q,
              token_length: count_q, error_code: ERR_NONE, end_of_run: 1'b0};
    dot_r = '{token_kind: KIND_DOT, start_line: st_line_q, start_column: dot_col,
              token_length: LEN_W'(1), error_code: ERR_NONE, end_of_run: 1'b0};
    sym_r = '{token_kind: sym_kind(pend_q), start_line: st_line_q,
              start_column: st_col_q, token_length: LEN_W'(1), error_code: ERR_NONE,
              end_of_run: 1'b0};
    end_r = '{token_kind: KIND_END, start_line: cur_line_q, start_column: cur_col_q,
              token_length: '0, error_code: ERR_NONE, end_of_run: 1'b0};
    n_res = 2'd0;
    rec0  = tok_r;
    rec1  = dot_r;
    if (eos) begin
      unique case (mode_q)
        MODE_IDENT: n_res = 2'd1;
        MODE_ZERO, MODE_DEC, MODE_HEX, MODE_FRAC: begin
          n_res = 2'd1;
          rec0.token_kind = KIND_NUMBER;
        end
        MODE_PNAME: begin
          n_res = 2'd1;
          rec0.token_kind = KIND_PCT;
        end
        MODE_HNAME: begin
          n_res = 2'd1;
          rec0.token_kind = KIND_HASH;
        end
        MODE_DECDOT: begin
          n_res = 2'd2;
          rec0.token_kind = KIND_NUMBER;
        end
        MODE_HASHDOT: begin
          n_res = 2'd2;
          rec0.token_kind = KIND_HASH;
        end
        MODE_SYM: begin
          n_res = 2'd1;
          rec0  = sym_r;
        end
        MODE_SLASH, MODE_MINUS, MODE_BAD: begin
          n_res = 2'd1;
          rec0.token_length = '0;
          rec0.error_code   = ERR_BADCHAR;
        end
        MODE_BLOCK, MODE_BLOCKSTAR: begin
          n_res = 2'd1;
          rec0.token_length = '0;
          rec0.error_code   = ERR_COMMENT;
        end
        MODE_HEX0: begin
          n_res = 2'd1;
          rec0.token_length = '0;
          rec0.error_code   = ERR_NOHEX;
        end
        MODE_STR: begin
          n_res = 2'd1;
          rec0.token_length = '0;
          rec0.error_code   = ERR_STRING;
        end
        MODE_PCT0, MODE_HASH0: begin
          n_res = 2'd1;
          rec0.token_length = '0;
          rec0.error_code   = ERR_NAME;
        end
        default: n_res = 2'd0;
      endcase
      // append the end record unless a trailing dot filled both slots
      if (n_res == 2'd0) begin
        rec0  = end_r;
        n_res = 2'd1;
      end else if (n_res == 2'd1) begin
        rec1  = end_r;
        n_res = 2'd2;
      end
    end else begin
      unique case (mode_q)
        MODE_IDENT: if (!is_alnum(ch)) n_res = 2'd1;
        MODE_PNAME: begin
          rec0.token_kind = KIND_PCT;
          if (!is_alnum(ch)) n_res = 2'd1;
        end
        MODE_ZERO: begin
          rec0.token_kind = KIND_NUMBER;
          if (ch != CH_LOWER_X && ch != CH_UPPER_X && !is_digit(ch) && ch != CH_DOT)
            n_res = 2'd1;
        end
        MODE_HEX: begin
          rec0.token_kind = KIND_NUMBER;
          if (!is_hex(ch)) n_res = 2'd1;
        end
        MODE_DEC: begin
          rec0.token_kind = KIND_NUMBER;
          if (!is_digit(ch) && ch != CH_DOT) n_res = 2'd1;
        end
        MODE_FRAC: begin
          rec0.token_kind = KIND_NUMBER;
          if (!is_digit(ch)) n_res = 2'd1;
        end
        MODE_DECDOT: begin
          rec0.token_kind = KIND_NUMBER;
          if (!is_digit(ch)) n_res = 2'd2;
        end
        MODE_HNAME: begin
          rec0.token_kind = KIND_HASH;
          if (!is_alnum(ch) && ch != CH_DOT) n_res = 2'd1;
        end
        MODE_HASHDOT: begin
          rec0.token_kind = KIND_HASH;
          if (!is_letter(ch)) n_res = 2'd2;
        end
        MODE_STR: begin
          // length counts the closing quote
          rec0.token_kind   = KIND_STRING;
          rec0.token_length = count_inc1;
          if (ch == CH_QUOTE && !esc_q) n_res = 2'd1;
        end
        MODE_SYM: begin
          rec0  = sym_r;
          n_res = 2'd1;
        end
        MODE_MINUS: begin
          rec0.token_length = '0;
          rec0.error_code   = ERR_BADCHAR;
          if (!is_digit(ch)) n_res = 2'd1;
        end
        MODE_SLASH: begin
          rec0.token_length = '0;
          rec0.error_code   = ERR_BADCHAR;
          if (ch != CH_SLASH && ch != CH_STAR) n_res = 2'd1;
        end
        MODE_BAD: begin
          rec0.token_length = '0;
          rec0.error_code   = ERR_BADCHAR;
          n_res = 2'd1;
        end
        MODE_HEX0: begin
          rec0.token_length = '0;
          rec0.error_code   = ERR_NOHEX;
          if (!is_hex(ch)) n_res = 2'd1;
        end
        MODE_PCT0, MODE_HASH0: begin
          rec0.token_length = '0;
          rec0.error_code   = ERR_NAME;
          if (!is_letter(ch)) n_res = 2'd1;
        end
        default: n_res = 2'd0;
      endcase
    end
    if (n_res == 2'd1) rec0.end_of_run = 1'b1;
    if (n_res == 2'd2) rec1.end_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      pend_q     <= '0;
      cur_line_q <= LINE_W'(1);
      cur_col_q  <= COL_W'(1);
      st_line_q  <= LINE_W'(1);
      st_col_q   <= COL_W'(1);
      count_q    <= '0;
      esc_q      <= 1'b0;
    end else if (in_fire) begin
      mode_q     <= mode_d;
      pend_q     <= pend_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      st_line_q  <= st_line_d;
      st_col_q   <= st_col_d;
      count_q    <= count_d;
      esc_q      <= esc_d;
    end
  end

  // result queue: up to two pushes and one pop per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      if (out_fire) head_q <= head_q + QPTR_W'(1);
      if (in_fire) tail_q <= tail_q + QPTR_W'(n_res);
      fill_q <= fill_q + (in_fire ? (QPTR_W+1)'(n_res) : '0) -
                (out_fire ? (QPTR_W+1)'(1) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && n_res != 2'd0) queue_q[tail_q] <= rec0;
    if (in_fire && n_res == 2'd2) queue_q[tail_q + QPTR_W'(1)] <= rec1;
  end

  assign in_ready_o  = (fill_q <= (QPTR_W+1)'(QDEPTH - 2));
  assign out_valid_o = (fill_q != '0);
  assign out_data_o  = queue_q[head_q];

endmodule

>>> src/stt_checker.sv
module stt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input stt_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input stt_pkg::out_t out_data_o
);
  import stt_pkg::*;

  // hold a stalled input word
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word dropped or changed while stalled");

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  // error records carry no kind and no length
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code != ERR_NONE |->
      out_data_o.token_kind == KIND_IDENT && out_data_o.token_length == '0)
    else $error("error record with kind or length set");

  // the end record closes its run
  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_kind == KIND_END |->
      out_data_o.end_of_run && out_data_o.error_code == ERR_NONE &&
      out_data_o.token_length == '0)
    else $error("malformed end record");

  // every token starts on a real line and column
  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.start_line != '0 && out_data_o.start_column != '0)
    else $error("record at line or column zero");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (.*);
